// ===== src/sbm_pkg.sv =====
package sbm_pkg;

    // Input actions.
    localparam logic [2:0] ACT_CPU_READ  = 3'd0;
    localparam logic [2:0] ACT_CPU_WRITE = 3'd1;
    localparam logic [2:0] ACT_PPU_READ  = 3'd2;
    localparam logic [2:0] ACT_PPU_WRITE = 3'd3;
    localparam logic [2:0] ACT_LOAD_PRG  = 3'd4;
    localparam logic [2:0] ACT_LOAD_CHR  = 3'd5;

    // Targets of a completed serial load, chosen by address bits 14:13.
    localparam logic [1:0] SEL_CONTROL   = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW   = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH  = 2'd2;
    localparam logic [1:0] SEL_PRG       = 2'd3;

    // Configuration register index (paddr bit 2).
    localparam logic REG_PRG_BANK_COUNT = 1'b0;

    // Mirroring modes.
    localparam logic [1:0] MIR_LOWER    = 2'd0;
    localparam logic [1:0] MIR_UPPER    = 2'd1;
    localparam logic [1:0] MIR_VERTICAL = 2'd2;

    // Fixed sizes.
    localparam int PRG_BANK_BYTES = 16384;
    localparam int CHR_BANK_BYTES = 4096;
    localparam int VRAM_BYTES     = 2048;
    localparam int WORK_RAM_BYTES = 8192;
    localparam int VRAM_AW        = $clog2(VRAM_BYTES);
    localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
    localparam int MEM_AW         = 18;
    localparam int SHIFT_BITS     = 5;

    // Reset values of the mode registers.
    localparam logic [1:0] PRG_MODE_RESET  = 2'd3;
    localparam logic [4:0] BANK_COUNT_RESET = 5'd16;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PRG,
        CMD_CHR,
        CMD_VRAM,
        CMD_WRAM
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [17:0] load_index;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       palette_hit;
        logic [4:0] palette_index;
    } result_t;

    // One classified word from the front to the back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic              write;
        logic [MEM_AW-1:0] mem_addr;
        logic [7:0]        data;
        logic              palette_hit;
        logic [4:0]        palette_index;
    } cmd_t;

endpackage

// ===== src/sbm_fifo.sv =====
module sbm_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/sbm_front.sv =====
module sbm_front
    import sbm_pkg::*;
#(
    parameter int PRG_BANKS = 16,
    parameter int CHR_BANKS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  logic        accept,
    input  item_t       item,
    output cmd_t        cmd
);

    localparam int PBW       = $clog2(PRG_BANKS);
    localparam int CBW       = $clog2(CHR_BANKS);
    localparam int PRG_BYTES = PRG_BANKS * PRG_BANK_BYTES;
    localparam int CHR_BYTES = CHR_BANKS * CHR_BANK_BYTES;

    logic [4:0] prg_bank_count_reg;
    logic [4:0] shift_value_reg,   shift_value_next;
    logic [2:0] shift_count_reg,   shift_count_next;
    logic [1:0] mirror_mode_reg,   mirror_mode_next;
    logic [1:0] prg_mode_reg,      prg_mode_next;
    logic       chr_mode_reg,      chr_mode_next;
    logic [4:0] chr_bank_low_reg,  chr_bank_low_next;
    logic [4:0] chr_bank_high_reg, chr_bank_high_next;
    logic [4:0] prg_bank_sel_reg,  prg_bank_sel_next;

    logic [4:0]  eff_banks;
    logic [4:0]  prg_bank;
    logic [4:0]  chr_bank;
    logic [13:0] ppu_addr;
    logic [11:0] nt_off;
    logic [10:0] nt_idx;
    logic [4:0]  shifted;
    logic [2:0]  count_inc;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= BANK_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_PRG_BANK_COUNT))
        begin
            prg_bank_count_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_PRG_BANK_COUNT) ? {27'd0, prg_bank_count_reg} : '0;

    // Number of usable PRG banks: a count of zero reads as one, and the count is clamped to the store size.
    always_comb
    begin
        if (prg_bank_count_reg == 5'd0)
        begin
            eff_banks = 5'd1;
        end
        else if (prg_bank_count_reg > 5'(PRG_BANKS))
        begin
            eff_banks = 5'(PRG_BANKS);
        end
        else
        begin
            eff_banks = prg_bank_count_reg;
        end
    end

    // PRG bank for the CPU window at 0x8000 (bit 14 picks the upper half).
    always_comb
    begin
        case (prg_mode_reg)
            2'd0, 2'd1:
            begin
                prg_bank = item.address[14] ? ((prg_bank_sel_reg & 5'h0E) + 5'd1)
                                            : (prg_bank_sel_reg & 5'h0E);
            end
            2'd2:
            begin
                prg_bank = item.address[14] ? (prg_bank_sel_reg & 5'h0F) : 5'd0;
            end
            default:
            begin
                prg_bank = item.address[14] ? (eff_banks - 5'd1)
                                            : (prg_bank_sel_reg & 5'h0F);
            end
        endcase
    end

    // CHR bank for the pattern table half selected by bit 12.
    assign ppu_addr = item.address[13:0];

    always_comb
    begin
        if (chr_mode_reg)
        begin
            chr_bank = ppu_addr[12] ? chr_bank_high_reg : chr_bank_low_reg;
        end
        else
        begin
            chr_bank = ppu_addr[12] ? ((chr_bank_low_reg & 5'h1E) + 5'd1)
                                    : (chr_bank_low_reg & 5'h1E);
        end
    end

    // Nametable index: 0x3000-0x3EFF folds onto 0x2000, so the offset is the low 12 bits.
    assign nt_off = ppu_addr[11:0];

    always_comb
    begin
        case (mirror_mode_reg)
            MIR_LOWER:    nt_idx = {1'b0, nt_off[9:0]};
            MIR_UPPER:    nt_idx = {1'b1, nt_off[9:0]};
            MIR_VERTICAL: nt_idx = nt_off[10:0];
            default:      nt_idx = {nt_off[11], nt_off[9:0]};
        endcase
    end

    // Classify the word into one memory access or none.
    always_comb
    begin
        cmd = '0;
        cmd.kind = CMD_NONE;
        cmd.data = item.data;
        case (item.action)
            ACT_CPU_READ, ACT_CPU_WRITE:
            begin
                cmd.write = (item.action == ACT_CPU_WRITE);
                if (item.address[15:13] == 3'b011)
                begin
                    cmd.kind     = CMD_WRAM;
                    cmd.mem_addr = MEM_AW'(item.address[WRAM_AW-1:0]);
                end
                else if (item.address[15] && !cmd.write && (prg_bank < eff_banks))
                begin
                    cmd.kind     = CMD_PRG;
                    cmd.mem_addr = MEM_AW'({prg_bank[PBW-1:0], item.address[13:0]});
                end
            end
            ACT_PPU_READ, ACT_PPU_WRITE:
            begin
                cmd.write = (item.action == ACT_PPU_WRITE);
                if (ppu_addr[13:8] == 6'h3F)
                begin
                    cmd.palette_hit   = 1'b1;
                    cmd.palette_index = ppu_addr[4:0];
                end
                else if (!ppu_addr[13])
                begin
                    if (32'(chr_bank) < CHR_BANKS)
                    begin
                        cmd.kind     = CMD_CHR;
                        cmd.mem_addr = MEM_AW'({chr_bank[CBW-1:0], ppu_addr[11:0]});
                    end
                end
                else
                begin
                    cmd.kind     = CMD_VRAM;
                    cmd.mem_addr = MEM_AW'(nt_idx);
                end
            end
            ACT_LOAD_PRG:
            begin
                cmd.write = 1'b1;
                if (32'(item.load_index) < PRG_BYTES)
                begin
                    cmd.kind     = CMD_PRG;
                    cmd.mem_addr = item.load_index;
                end
            end
            ACT_LOAD_CHR:
            begin
                cmd.write = 1'b1;
                if (32'(item.load_index) < CHR_BYTES)
                begin
                    cmd.kind     = CMD_CHR;
                    cmd.mem_addr = item.load_index;
                end
            end
            default:
            begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

    // Serial load register and the mode registers it feeds.
    assign shifted   = shift_value_reg | (5'(item.data[0]) << shift_count_reg);
    assign count_inc = shift_count_reg + 3'd1;

    always_comb
    begin
        shift_value_next   = shift_value_reg;
        shift_count_next   = shift_count_reg;
        mirror_mode_next   = mirror_mode_reg;
        prg_mode_next      = prg_mode_reg;
        chr_mode_next      = chr_mode_reg;
        chr_bank_low_next  = chr_bank_low_reg;
        chr_bank_high_next = chr_bank_high_reg;
        prg_bank_sel_next  = prg_bank_sel_reg;
        if (accept && (item.action == ACT_CPU_WRITE) && item.address[15])
        begin
            if (item.data[7])
            begin
                shift_value_next = '0;
                shift_count_next = '0;
            end
            else if (count_inc >= 3'(SHIFT_BITS))
            begin
                shift_value_next = '0;
                shift_count_next = '0;
                case (item.address[14:13])
                    SEL_CONTROL:
                    begin
                        mirror_mode_next = shifted[1:0];
                        prg_mode_next    = shifted[3:2];
                        chr_mode_next    = shifted[4];
                    end
                    SEL_CHR_LOW:  chr_bank_low_next  = shifted;
                    SEL_CHR_HIGH: chr_bank_high_next = shifted;
                    default:      prg_bank_sel_next  = shifted;
                endcase
            end
            else
            begin
                shift_value_next = shifted;
                shift_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_value_reg   <= '0;
            shift_count_reg   <= '0;
            mirror_mode_reg   <= '0;
            prg_mode_reg      <= PRG_MODE_RESET;
            chr_mode_reg      <= 1'b0;
            chr_bank_low_reg  <= '0;
            chr_bank_high_reg <= '0;
            prg_bank_sel_reg  <= '0;
        end
        else
        begin
            shift_value_reg   <= shift_value_next;
            shift_count_reg   <= shift_count_next;
            mirror_mode_reg   <= mirror_mode_next;
            prg_mode_reg      <= prg_mode_next;
            chr_mode_reg      <= chr_mode_next;
            chr_bank_low_reg  <= chr_bank_low_next;
            chr_bank_high_reg <= chr_bank_high_next;
            prg_bank_sel_reg  <= prg_bank_sel_next;
        end
    end

endmodule

// ===== src/sbm_back.sv =====
module sbm_back
    import sbm_pkg::*;
#(
    parameter int PRG_BANKS = 16,
    parameter int CHR_BANKS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    ready,
    input  logic    result_pop,
    output logic    result_empty,
    output result_t result
);

    localparam int PRG_BYTES = PRG_BANKS * PRG_BANK_BYTES;
    localparam int CHR_BYTES = CHR_BANKS * CHR_BANK_BYTES;
    localparam int PRG_AW    = $clog2(PRG_BYTES);
    localparam int CHR_AW    = $clog2(CHR_BYTES);
    localparam int RES_DEPTH = 4;
    localparam int RCW       = $clog2(RES_DEPTH + 1);

    logic [7:0] prg_mem  [PRG_BYTES];
    logic [7:0] chr_mem  [CHR_BYTES];
    logic [7:0] vram_mem [VRAM_BYTES];
    logic [7:0] wram_mem [WORK_RAM_BYTES];

    logic [7:0] prg_rd_reg, chr_rd_reg, vram_rd_reg, wram_rd_reg;

    logic              clearing_reg;
    logic [CHR_AW-1:0] clr_idx_reg;

    logic         s1_valid_reg;
    cmd_kind_t    s1_kind_reg;
    logic         s1_read_reg;
    logic         s1_hit_reg;
    logic [4:0]   s1_pidx_reg;

    logic [RCW-1:0] res_count;
    logic           res_full;
    logic           issue;
    result_t        res_word;

    logic              prg_we, chr_we, vram_we, wram_we;
    logic [CHR_AW-1:0] chr_addr;
    logic [VRAM_AW-1:0] vram_addr;
    logic [WRAM_AW-1:0] wram_addr;
    logic [7:0]        fill_data;

    // Clearing pass over the zero-reset stores after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == CHR_AW'(CHR_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign ready = !clearing_reg;

    // Issue when the result queue has room for everything in flight.
    assign issue   = cmd_valid && !clearing_reg
                     && ((32'(res_count) + 32'(s1_valid_reg)) < RES_DEPTH);
    assign cmd_pop = issue;

    // Memory port controls.
    assign fill_data = clearing_reg ? 8'd0 : cmd.data;
    assign prg_we    = issue && cmd.write && (cmd.kind == CMD_PRG);
    assign chr_we    = clearing_reg || (issue && cmd.write && (cmd.kind == CMD_CHR));
    assign vram_we   = (clearing_reg && (32'(clr_idx_reg) < VRAM_BYTES))
                       || (issue && cmd.write && (cmd.kind == CMD_VRAM));
    assign wram_we   = (clearing_reg && (32'(clr_idx_reg) < WORK_RAM_BYTES))
                       || (issue && cmd.write && (cmd.kind == CMD_WRAM));
    assign chr_addr  = clearing_reg ? clr_idx_reg : cmd.mem_addr[CHR_AW-1:0];
    assign vram_addr = clearing_reg ? clr_idx_reg[VRAM_AW-1:0] : cmd.mem_addr[VRAM_AW-1:0];
    assign wram_addr = clearing_reg ? clr_idx_reg[WRAM_AW-1:0] : cmd.mem_addr[WRAM_AW-1:0];

    // PRG store.
    always_ff @(posedge clk)
    begin
        if (prg_we)
        begin
            prg_mem[cmd.mem_addr[PRG_AW-1:0]] <= cmd.data;
        end
        prg_rd_reg <= prg_mem[cmd.mem_addr[PRG_AW-1:0]];
    end

    // CHR store.
    always_ff @(posedge clk)
    begin
        if (chr_we)
        begin
            chr_mem[chr_addr] <= fill_data;
        end
        chr_rd_reg <= chr_mem[chr_addr];
    end

    // Nametable RAM.
    always_ff @(posedge clk)
    begin
        if (vram_we)
        begin
            vram_mem[vram_addr] <= fill_data;
        end
        vram_rd_reg <= vram_mem[vram_addr];
    end

    // Work RAM.
    always_ff @(posedge clk)
    begin
        if (wram_we)
        begin
            wram_mem[wram_addr] <= fill_data;
        end
        wram_rd_reg <= wram_mem[wram_addr];
    end

    // Access stage: remembers what the memories are answering.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg <= cmd.kind;
            s1_read_reg <= !cmd.write;
            s1_hit_reg  <= cmd.palette_hit;
            s1_pidx_reg <= cmd.palette_index;
        end
    end

    // Result word.
    always_comb
    begin
        res_word = '0;
        res_word.palette_hit   = s1_hit_reg;
        res_word.palette_index = s1_pidx_reg;
        if (s1_read_reg)
        begin
            case (s1_kind_reg)
                CMD_PRG:  res_word.read_data = prg_rd_reg;
                CMD_CHR:  res_word.read_data = chr_rd_reg;
                CMD_VRAM: res_word.read_data = vram_rd_reg;
                CMD_WRAM: res_word.read_data = wram_rd_reg;
                default:  res_word.read_data = 8'd0;
            endcase
        end
    end

    sbm_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s1_valid_reg),
        .wdata (res_word),
        .full  (res_full),
        .pop   (result_pop),
        .rdata (result),
        .empty (result_empty),
        .count (res_count)
    );

endmodule

// ===== src/serial_bank_mapper.sv =====
// An accepted word passes the command queue, the read registers and the result queue.
// Throughput: one word per cycle, sustained, while results are popped as they appear.
// Each word makes at most one access to a single-port synchronous memory.
// Reset: all control state clears at once; then a clearing pass zeroes CHR, nametable and
// work RAM, walking every CHR address in turn, with full held high.
module serial_bank_mapper
    import sbm_pkg::*;
#(
    parameter int PRG_BANKS = 16,
    parameter int CHR_BANKS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  item_t       item,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    logic accept;
    logic back_ready;
    cmd_t front_cmd;
    cmd_t queued_cmd;
    logic cmdq_full;
    logic cmdq_empty;
    logic cmdq_pop;

    assign pready = 1'b1;
    assign full   = cmdq_full || !back_ready;
    assign accept = push && !full;

    sbm_front #(
        .PRG_BANKS (PRG_BANKS),
        .CHR_BANKS (CHR_BANKS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .accept  (accept),
        .item    (item),
        .cmd     (front_cmd)
    );

    // Short queue between classification and memory access.
    sbm_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (cmdq_pop),
        .rdata (queued_cmd),
        .empty (cmdq_empty),
        .count ()
    );

    sbm_back #(
        .PRG_BANKS (PRG_BANKS),
        .CHR_BANKS (CHR_BANKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cmdq_empty),
        .cmd          (queued_cmd),
        .cmd_pop      (cmdq_pop),
        .ready        (back_ready),
        .result_pop   (pop),
        .result_empty (empty),
        .result       (result)
    );

endmodule

// ===== src/sbm_checker.sv =====
module sbm_checker
    import sbm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        push,
    input logic        full,
    input item_t       item,
    input logic        empty,
    input logic        pop,
    input result_t     result
);

    // The result queue is empty in the cycle after reset is sampled low.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // The clearing pass keeps the input closed as reset ends.
    a_clear_blocks: assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("input open while memories are being cleared");

    // A bank count read right after its write returns the written value.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_PRG_BANK_COUNT))
        ##1 (psel && !pwrite && (paddr[2] == REG_PRG_BANK_COUNT))
        |-> (prdata == {27'd0, $past(pwdata[4:0])}))
        else $error("bank count readback mismatch");

    // A palette access never carries read data, and the index is zero without a hit.
    a_palette_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.palette_hit && (result.read_data == 8'd0))
                    || (!result.palette_hit && (result.palette_index == 5'd0))))
        else $error("palette fields inconsistent");

    // A waiting result word holds until it is popped.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind serial_bank_mapper sbm_checker u_sbm_checker (.*);
